/* rtl/gsv_pkg.sv */
package gsv_pkg;

  localparam int SQUARE_COLUMNS = 20;
  localparam int SQUARE_TOTAL   = 300;

  // Intra store: one byte per entry, enough for eight rows of four bytes.
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // A square ID that passed the range check fits in ID_W bits.
  localparam int ID_W  = $clog2(SQUARE_TOTAL + 1);
  localparam int COL_W = $clog2(SQUARE_COLUMNS + 1);

  // Division by SQUARE_COLUMNS through a truncated reciprocal. The estimate
  // is low by at most one, which a single compare and subtract corrects.
  localparam int DIV_S  = ID_W + $clog2(SQUARE_COLUMNS) + 1;
  localparam int DIV_M  = (2 ** DIV_S) / SQUARE_COLUMNS;
  localparam int PROD_W = ID_W + DIV_S + 1;
  localparam int REM_W  = ID_W + COL_W + 1;

  localparam logic [31:0] PRED_INIT = 32'h8888_8888;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } gsv_in_t;

  typedef struct packed {
    logic        is_row_write;
    logic [4:0]  square_column;
    logic [6:0]  pixel_row;
    logic [31:0] row_pixels;
    logic [15:0] squares_decoded;
    logic        last;
  } gsv_out_t;

  // Work handed from the byte parser to the row generator.
  typedef struct packed {
    logic        rows;
    logic        sum;
    logic [31:0] codes;
    logic [4:0]  col;
    logic [6:0]  base;
    logic [15:0] count;
  } gsv_job_t;

  function automatic logic [2:0] intra_bytes(input logic [3:0] code);
    logic [2:0] n;
    unique case (code)
      4'd0:                                   n = 3'd4;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:         n = 3'd0;
      4'd2, 4'd5, 4'd8, 4'd11, 4'd14:         n = 3'd1;
      default:                                n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] inter_const(input logic [3:0] code);
    logic [31:0] v;
    unique case (code)
      4'd1:                 v = 32'hDDDD_DDDE;
      4'd2, 4'd4:           v = 32'hEEEE_EEEF;
      4'd6, 4'd8, 4'd10:    v = 32'h1111_1111;
      4'd9, 4'd11, 4'd13:   v = 32'h2222_2222;
      4'd12, 4'd14:         v = 32'h3333_3333;
      4'd15:                v = 32'h4444_4444;
      default:              v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] spread8(input logic [7:0] b);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k] = b[k];
    end
    return r;
  endfunction

  function automatic logic [31:0] spread16(input logic [15:0] w);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 2] = w[2*k +: 2];
    end
    return r;
  endfunction

endpackage

/* rtl/gsv_ram.sv */
module gsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gsv_parse.sv */
module gsv_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  gsv_pkg::gsv_in_t         in_beat,
  output logic                     wr_en,
  output logic [gsv_pkg::ADDR_W-1:0] wr_addr,
  output logic [7:0]               wr_data,
  output gsv_pkg::gsv_job_t        job
);
  import gsv_pkg::*;

  localparam logic [1:0] PH_ID_HI = 2'd0;
  localparam logic [1:0] PH_ID_LO = 2'd1;
  localparam logic [1:0] PH_CODES = 2'd2;
  localparam logic [1:0] PH_INTRA = 2'd3;

  logic [1:0]      phase_r, phase_nxt;
  logic [1:0]      hdr_r, hdr_nxt;
  logic            stopped_r, stopped_nxt;
  logic [5:0]      need_r, need_nxt;
  logic [5:0]      recv_r, recv_nxt;
  logic [15:0]     count_r, count_nxt;
  logic [7:0]      id_hi_r, id_hi_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [31:0]     codes_r, codes_nxt;

  logic [ID_W-1:0]   qa_r, q_r, q_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  qd, rem;

  logic [15:0] id16;
  logic [31:0] codes_shift;
  logic [5:0]  need_sum;
  logic [5:0]  recv_inc;
  logic [15:0] count_upd;
  logic        done;

  // Column and row band of the current ID, registered via qa_r.
  always_comb begin
    prod = PROD_W'(id_r) * PROD_W'(DIV_M);
    qd   = REM_W'(qa_r) * REM_W'(SQUARE_COLUMNS);
    rem  = REM_W'(id_r) - qd;
    if (rem >= REM_W'(SQUARE_COLUMNS)) begin
      q_nxt   = qa_r + ID_W'(1);
      col_nxt = COL_W'(rem - REM_W'(SQUARE_COLUMNS));
    end else begin
      q_nxt   = qa_r;
      col_nxt = COL_W'(rem);
    end
  end

  always_comb begin
    id16        = {id_hi_r, in_beat.data_byte};
    codes_shift = {codes_r[23:0], in_beat.data_byte};
    recv_inc    = recv_r + 6'd1;
    need_sum    = '0;
    for (int k = 0; k < 8; k++) begin
      need_sum = need_sum + 6'(intra_bytes(codes_shift[4*k +: 4]));
    end

    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    stopped_nxt = stopped_r;
    need_nxt    = need_r;
    recv_nxt    = recv_r;
    id_hi_nxt   = id_hi_r;
    id_nxt      = id_r;
    codes_nxt   = codes_r;
    done        = 1'b0;
    wr_en       = 1'b0;

    if (accept && !stopped_r) begin
      unique case (phase_r)
        PH_ID_HI: begin
          id_hi_nxt = in_beat.data_byte;
          phase_nxt = PH_ID_LO;
        end
        PH_ID_LO: begin
          if (id16 >= 16'(SQUARE_TOTAL)) begin
            stopped_nxt = 1'b1;
          end else begin
            id_nxt    = ID_W'(id16);
            hdr_nxt   = 2'd0;
            phase_nxt = PH_CODES;
          end
        end
        PH_CODES: begin
          codes_nxt = codes_shift;
          hdr_nxt   = hdr_r + 2'd1;
          if (hdr_r == 2'd3) begin
            need_nxt = need_sum;
            recv_nxt = '0;
            if (need_sum == 6'd0) begin
              done      = 1'b1;
              phase_nxt = PH_ID_HI;
            end else begin
              phase_nxt = PH_INTRA;
            end
          end
        end
        PH_INTRA: begin
          wr_en    = 1'b1;
          recv_nxt = recv_inc;
          if (recv_inc >= need_r) begin
            done      = 1'b1;
            phase_nxt = PH_ID_HI;
          end
        end
      endcase
    end

    count_upd = (done && count_r != 16'hFFFF) ? count_r + 16'd1 : count_r;
    count_nxt = count_upd;

    // Packet end returns the parser to the start of a square.
    if (accept && in_beat.end_of_packet) begin
      phase_nxt   = PH_ID_HI;
      hdr_nxt     = 2'd0;
      stopped_nxt = 1'b0;
      count_nxt   = '0;
    end

    job.rows  = done;
    job.sum   = accept && in_beat.end_of_packet;
    job.codes = codes_nxt;
    job.col   = 5'(col_r);
    job.base  = 7'({q_r, 3'b000});
    job.count = count_upd;
  end

  assign wr_addr = recv_r[ADDR_W-1:0];
  assign wr_data = in_beat.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ID_HI;
      hdr_r     <= '0;
      stopped_r <= 1'b0;
      need_r    <= '0;
      recv_r    <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_r     <= hdr_nxt;
      stopped_r <= stopped_nxt;
      need_r    <= need_nxt;
      recv_r    <= recv_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_hi_r <= id_hi_nxt;
    id_r    <= id_nxt;
    codes_r <= codes_nxt;
    qa_r    <= ID_W'(prod >> DIV_S);
    q_r     <= q_nxt;
    col_r   <= col_nxt;
  end

endmodule

/* rtl/gsv_rows.sv */
module gsv_rows (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gsv_pkg::gsv_job_t          job,
  output logic [gsv_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gsv_pkg::gsv_out_t          out_beat
);
  import gsv_pkg::*;

  localparam logic [1:0] R_IDLE  = 2'd0;
  localparam logic [1:0] R_FETCH = 2'd1;
  localparam logic [1:0] R_SUM   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [2:0]        kcnt_r, kcnt_nxt;
  logic              pend_r, pend_nxt;
  logic              eop_r, eop_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [31:0] codes_r, codes_nxt;
  logic [4:0]  col_r, col_nxt;
  logic [6:0]  base_r, base_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] prev_r, prev_nxt;
  gsv_out_t    out_r, out_nxt;

  logic [3:0]  code;
  logic [2:0]  nb;
  logic        issue;
  logic        row_ready;
  logic        slot_free;
  logic [31:0] intra;
  logic [31:0] row_val;

  always_comb begin
    code      = codes_r[31:28];
    nb        = intra_bytes(code);
    issue     = (state_r == R_FETCH) && (kcnt_r < nb);
    row_ready = (state_r == R_FETCH) && (kcnt_r == nb) && !pend_r;
    slot_free = !out_valid_r || !out_stall;

    priority if (nb == 3'd1) begin
      intra = spread8(acc_r[7:0]);
    end else if (nb == 3'd2) begin
      intra = spread16(acc_r[15:0]);
    end else begin
      intra = '0;
    end
    row_val = (nb == 3'd4) ? acc_r : prev_r - inter_const(code) + intra;

    state_nxt     = state_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    kcnt_nxt      = kcnt_r;
    pend_nxt      = issue;
    eop_nxt       = eop_r;
    codes_nxt     = codes_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    count_nxt     = count_r;
    acc_nxt       = pend_r ? {acc_r[23:0], rd_data} : acc_r;
    prev_nxt      = prev_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      R_IDLE: begin
        if (job.rows || job.sum) begin
          codes_nxt = job.codes;
          col_nxt   = job.col;
          base_nxt  = job.base;
          count_nxt = job.count;
          eop_nxt   = job.sum;
          row_nxt   = '0;
          idx_nxt   = '0;
          kcnt_nxt  = '0;
          prev_nxt  = PRED_INIT;
          state_nxt = job.rows ? R_FETCH : R_SUM;
        end
      end
      R_FETCH: begin
        if (issue) begin
          idx_nxt  = idx_r + ADDR_W'(1);
          kcnt_nxt = kcnt_r + 3'd1;
        end
        if (row_ready && slot_free) begin
          out_nxt.is_row_write    = 1'b1;
          out_nxt.square_column   = col_r;
          out_nxt.pixel_row       = base_r | {4'd0, row_r};
          out_nxt.row_pixels      = row_val;
          out_nxt.squares_decoded = '0;
          out_nxt.last            = (row_r == 3'd7) && !eop_r;
          out_valid_nxt           = 1'b1;
          prev_nxt                = row_val;
          row_nxt                 = row_r + 3'd1;
          kcnt_nxt                = '0;
          codes_nxt               = {codes_r[27:0], 4'd0};
          if (row_r == 3'd7) begin
            state_nxt = eop_r ? R_SUM : R_IDLE;
          end
        end
      end
      R_SUM: begin
        if (slot_free) begin
          out_nxt.is_row_write    = 1'b0;
          out_nxt.square_column   = '0;
          out_nxt.pixel_row       = '0;
          out_nxt.row_pixels      = '0;
          out_nxt.squares_decoded = count_r;
          out_nxt.last            = 1'b1;
          out_valid_nxt           = 1'b1;
          state_nxt               = R_IDLE;
        end
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  assign rd_addr   = idx_r;
  assign busy      = (state_r != R_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= R_IDLE;
      row_r       <= '0;
      idx_r       <= '0;
      kcnt_r      <= '0;
      pend_r      <= 1'b0;
      eop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      idx_r       <= idx_nxt;
      kcnt_r      <= kcnt_nxt;
      pend_r      <= pend_nxt;
      eop_r       <= eop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    codes_r <= codes_nxt;
    col_r   <= col_nxt;
    base_r  <= base_nxt;
    count_r <= count_nxt;
    acc_r   <= acc_nxt;
    prev_r  <= prev_nxt;
    out_r   <= out_nxt;
  end

  a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (job.rows || job.sum) |-> (state_r == R_IDLE))
    else $error("new job arrived while the row generator was busy");

  a_pend_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == R_FETCH))
    else $error("store read outstanding outside of row fetch");

  a_eighth_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (row_ready && slot_free && row_r == 3'd7) |=>
      (state_r == R_IDLE || state_r == R_SUM))
    else $error("row generator kept fetching after the eighth row");

endmodule

/* rtl/gray_square_video_decoder.sv */
// Gray square video decoder.
// The input channel (in_valid, in_stall, in_beat) carries one packet byte per
// beat together with an end-of-packet flag. The result channel (out_valid,
// out_stall, out_beat) carries row writes and one summary beat per packet.
// While a square is being parsed, one byte is taken every cycle. The byte
// that completes a square starts eight row writes; in_stall stays high until
// they, and the summary if that byte also ended the packet, are handed to
// the output register. A row that uses intra bytes reads them one at a time
// through the single, registered read port of the intra store.
// A stalled receiver simply holds the output register; the row generator
// waits and the input stays stalled while the generator is busy.
// Synchronous reset (rst_n low) returns the parser to the first ID byte,
// clears the square count and empties the output register. The intra
// store is not cleared; every byte is written before it is read.
module gray_square_video_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsv_pkg::gsv_in_t  in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output gsv_pkg::gsv_out_t out_beat
);
  import gsv_pkg::*;

  logic              accept;
  logic              busy;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  gsv_job_t          job;

  // The parser only writes the store and the row generator only reads it,
  // and never in overlapping windows, so no forwarding is required.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  gsv_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_beat (in_beat),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .job     (job)
  );

  gsv_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_intra_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  gsv_rows u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

/* sim/tb.sv */
module tb;
  import gsv_pkg::*;

  // Every row chain starts from mid gray in all eight pixels.
  localparam logic [31:0] ROW_SEED = 32'h8888_8888;

  typedef enum logic [1:0] {
    WANT_ID_HI,
    WANT_ID_LO,
    WANT_CODES,
    WANT_INTRA
  } parse_phase_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gsv_in_t  in_beat = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gsv_out_t out_beat;

  gray_square_video_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always #10 clk = ~clk;

  // Idle rates in percent per cycle for the sender and the receiver. While
  // calm_left counts down, neither side idles, so quiet bursts also occur
  // inside the idling phases.
  int idle_pct = 0;
  int stall_pct = 0;
  int calm_left = 0;
  int mismatches = 0;
  int bytes_sent = 0;

  // Rows and summaries predicted from the accepted bytes, oldest first.
  gsv_out_t pending_beats[$];
  // Bytes of the packet that is about to be sent.
  logic [7:0] pkt_bytes[$];

  // Shadow of the decoder's packet parser.
  parse_phase_t phase;
  logic        halted;
  logic [15:0] square_id;
  logic [31:0] row_codes;
  int          codes_seen;
  int          intra_need;
  int          intra_got;
  logic [7:0]  intra_bytes_seen[32];
  logic [15:0] squares_done;

  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      calm_left <= 30 + $urandom_range(0, 30);
    end
  end

  always @(negedge clk) begin
    out_stall <= (calm_left == 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Number of intra bytes a row code consumes. Code 0 is a literal row; the
  // others repeat in groups of three with 0, 1 and 2 bytes.
  function automatic int intra_len(input logic [3:0] code);
    if (code == 4'd0) begin
      return 4;
    end
    case (code % 3)
      1: return 0;
      2: return 1;
      default: return 2;
    endcase
  endfunction

  // Value taken away from the previous row before the intra bits are added.
  function automatic logic [31:0] inter_offset(input logic [3:0] code);
    case (code)
      4'd1: return 32'hDDDD_DDDE;
      4'd2, 4'd4: return 32'hEEEE_EEEF;
      4'd6, 4'd8, 4'd10: return 32'h1111_1111;
      4'd9, 4'd11, 4'd13: return 32'h2222_2222;
      4'd12, 4'd14: return 32'h3333_3333;
      4'd15: return 32'h4444_4444;
      default: return 32'h0;
    endcase
  endfunction

  task automatic reset_parser();
    phase = WANT_ID_HI;
    halted = 1'b0;
    square_id = '0;
    row_codes = '0;
    codes_seen = 0;
    intra_need = 0;
    intra_got = 0;
    squares_done = '0;
  endtask

  // Expands the buffered square into its eight row writes and counts it.
  task automatic decode_square();
    gsv_out_t    r;
    logic [31:0] prev;
    logic [31:0] intra;
    logic [15:0] pair;
    logic [3:0]  c;
    int          k;
    int          i;
    int          j;
    int          len;
    prev = ROW_SEED;
    k = 0;
    for (i = 0; i < 8; i++) begin
      c = row_codes[31 - 4*i -: 4];
      len = intra_len(c);
      r = '0;
      r.is_row_write = 1'b1;
      r.square_column = 5'(square_id % SQUARE_COLUMNS);
      r.pixel_row = 7'((square_id / SQUARE_COLUMNS) * 8 + i);
      if (len == 4) begin
        r.row_pixels = {intra_bytes_seen[k], intra_bytes_seen[k+1],
                        intra_bytes_seen[k+2], intra_bytes_seen[k+3]};
      end else begin
        intra = '0;
        if (len == 1) begin
          for (j = 0; j < 8; j++) begin
            intra[4*j] = intra_bytes_seen[k][j];
          end
        end else if (len == 2) begin
          pair = {intra_bytes_seen[k], intra_bytes_seen[k+1]};
          for (j = 0; j < 8; j++) begin
            intra[4*j +: 2] = pair[2*j +: 2];
          end
        end
        r.row_pixels = prev - inter_offset(c) + intra;
      end
      prev = r.row_pixels;
      k += len;
      pending_beats.push_back(r);
    end
    if (squares_done != 16'hFFFF) begin
      squares_done++;
    end
  endtask

  // Advances the shadow parser by one accepted byte and queues its results.
  task automatic decode_byte(input gsv_in_t b);
    gsv_out_t r;
    int       before_cnt;
    int       i;
    before_cnt = pending_beats.size();
    if (!halted) begin
      case (phase)
        WANT_ID_HI: begin
          square_id = {b.data_byte, 8'h00};
          phase = WANT_ID_LO;
        end
        WANT_ID_LO: begin
          square_id[7:0] = b.data_byte;
          if (square_id >= SQUARE_TOTAL) begin
            halted = 1'b1;
          end else begin
            phase = WANT_CODES;
            codes_seen = 0;
            row_codes = '0;
          end
        end
        WANT_CODES: begin
          row_codes = {row_codes[23:0], b.data_byte};
          codes_seen++;
          if (codes_seen == 4) begin
            intra_need = 0;
            for (i = 0; i < 8; i++) begin
              intra_need += intra_len(row_codes[4*i +: 4]);
            end
            intra_got = 0;
            if (intra_need == 0) begin
              decode_square();
              phase = WANT_ID_HI;
            end else begin
              phase = WANT_INTRA;
            end
          end
        end
        default: begin
          intra_bytes_seen[intra_got % 32] = b.data_byte;
          intra_got++;
          if (intra_got >= intra_need) begin
            decode_square();
            phase = WANT_ID_HI;
          end
        end
      endcase
    end
    if (b.end_of_packet) begin
      r = '0;
      r.squares_decoded = squares_done;
      pending_beats.push_back(r);
      reset_parser();
    end
    // The final result of each byte carries the last flag.
    if (pending_beats.size() > before_cnt) begin
      r = pending_beats.pop_back();
      r.last = 1'b1;
      pending_beats.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Every result beat taken by the receiver is checked against the oldest
  // prediction.
  always @(posedge clk) begin : watch_results
    gsv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", out_beat));
      end else begin
        want = pending_beats.pop_front();
        check_field("is_row_write", 32'(out_beat.is_row_write),
                    32'(want.is_row_write));
        check_field("square_column", 32'(out_beat.square_column),
                    32'(want.square_column));
        check_field("pixel_row", 32'(out_beat.pixel_row), 32'(want.pixel_row));
        check_field("row_pixels", out_beat.row_pixels, want.row_pixels);
        check_field("squares_decoded", 32'(out_beat.squares_decoded),
                    32'(want.squares_decoded));
        check_field("last", 32'(out_beat.last), 32'(want.last));
      end
    end
  end

  // Presents one byte and waits for its acceptance. Valid is left high after
  // the beat, so the next call either moves straight to the next byte or
  // drops valid for a gap.
  task automatic send_byte(input logic [7:0] d, input logic eop);
    @(negedge clk);
    while (calm_left == 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_beat.data_byte = d;
    in_beat.end_of_packet = eop;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    decode_byte(in_beat);
    bytes_sent++;
  endtask

  // Sends the buffered bytes; close marks the final one as the packet end.
  task automatic send_packet(input bit close);
    int i;
    for (i = 0; i < pkt_bytes.size(); i++) begin
      send_byte(pkt_bytes[i], close && (i == pkt_bytes.size() - 1));
    end
  endtask

  // Appends one complete square with a random ID and random row codes.
  task automatic add_random_square();
    logic [15:0] id;
    logic [31:0] codes;
    logic [3:0]  pick;
    int          need;
    int          i;
    id = 16'($urandom_range(0, SQUARE_TOTAL - 1));
    case ($urandom_range(0, 9))
      0: codes = '0;
      1: begin
        for (i = 0; i < 8; i++) begin
          pick = 4'(1 + 3 * $urandom_range(0, 4));
          codes[4*i +: 4] = pick;
        end
      end
      default: codes = $urandom();
    endcase
    need = 0;
    for (i = 0; i < 8; i++) begin
      need += intra_len(codes[4*i +: 4]);
    end
    pkt_bytes.push_back(id[15:8]);
    pkt_bytes.push_back(id[7:0]);
    for (i = 3; i >= 0; i--) begin
      pkt_bytes.push_back(codes[8*i +: 8]);
    end
    for (i = 0; i < need; i++) begin
      pkt_bytes.push_back(8'($urandom()));
    end
  endtask

  // Mostly well-formed packets with random content; the rest carry an
  // out-of-range ID, end in the middle of a square, or are plain noise.
  task automatic run_random_packets(input int budget);
    logic [15:0] bad_id;
    int          stop_at;
    int          flavor;
    int          n;
    int          i;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pkt_bytes.delete();
      flavor = $urandom_range(0, 99);
      n = $urandom_range(0, 4);
      if (flavor < 96) begin
        for (i = 0; i < n; i++) begin
          add_random_square();
        end
      end
      if (flavor >= 80 && flavor < 88) begin
        bad_id = 16'($urandom_range(SQUARE_TOTAL, 16'hFFFF));
        pkt_bytes.push_back(bad_id[15:8]);
        pkt_bytes.push_back(bad_id[7:0]);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
          pkt_bytes.push_back(8'($urandom()));
        end
      end else if (flavor >= 88 && flavor < 96) begin
        add_random_square();
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          pkt_bytes.pop_back();
        end
      end else if (flavor >= 96) begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
          pkt_bytes.push_back(8'($urandom()));
        end
      end
      if (pkt_bytes.size() == 0) begin
        pkt_bytes.push_back(8'($urandom()));
      end
      send_packet(1'b1);
    end
  endtask

  // Two squares that together use all sixteen row codes. The second has the
  // highest legal ID, so it lands in the last column and the bottom rows,
  // and its final byte ends the packet, giving eight rows plus a summary.
  task automatic test_every_row_code();
    pkt_bytes = '{8'h00, 8'h00, 8'h89, 8'hAB, 8'hCD, 8'hEF,
                  8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'hC3,
                  8'h01, 8'h2B, 8'h01, 8'h23, 8'h45, 8'h67,
                  8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h0F, 8'hF0, 8'h3C, 8'h81, 8'h42,
                  8'h24};
    send_packet(1'b1);
  endtask

  // The first out-of-range ID stops decoding; the byte after it is ignored
  // apart from its end-of-packet flag.
  task automatic test_bad_square_id();
    pkt_bytes = '{8'h01, 8'h2C, 8'h42};
    send_packet(1'b1);
  endtask

  // A square cut short by the packet end is dropped and not counted. The
  // packet after it is a single byte, which only yields a summary.
  task automatic test_truncated_square();
    pkt_bytes = '{8'h00, 8'h05, 8'h00, 8'h00};
    send_packet(1'b1);
    pkt_bytes = '{8'hA5};
    send_packet(1'b1);
  endtask

  task automatic test_no_idling();
    idle_pct = 0;
    stall_pct = 0;
    run_random_packets(125);
  endtask

  task automatic test_sender_gaps();
    idle_pct = 58;
    stall_pct = 0;
    run_random_packets(125);
  endtask

  task automatic test_receiver_stalls();
    idle_pct = 0;
    stall_pct = 58;
    run_random_packets(125);
  endtask

  task automatic test_both_idle();
    idle_pct = 36;
    stall_pct = 36;
    run_random_packets(125);
  endtask

  initial begin
    reset_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_every_row_code();
    test_bad_square_id();
    test_truncated_square();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    @(negedge clk);
    in_valid = 1'b0;
    // Let the last rows drain, then watch a little longer for stray beats.
    while (pending_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("tb failed");
    $finish;
  end

endmodule
